// File: hw/rtl/umc_pkg.sv
// Shared types, constants and helpers for the union-find maze carver.
package umc_pkg;

  localparam int unsigned MAX_ROOMS_DFLT = 1024;
  localparam int unsigned ROOM_W         = 10;
  localparam int unsigned DIM_W          = 6;
  localparam int unsigned SIZE_W         = ROOM_W + 1;
  localparam int unsigned PROD_W         = 2 * DIM_W;
  localparam int unsigned WALL_W         = 4;
  localparam int unsigned DIM_MAX        = 32;
  localparam int unsigned DIM_RESET      = 8;

  localparam logic [WALL_W-1:0] WALLS_ALL = 4'hF;

  localparam logic CFG_WIDE   = 1'b0;
  localparam logic CFG_HIGH   = 1'b1;
  localparam logic KIND_TRY   = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  typedef enum logic [1:0] {
    OUT_REMOVED   = 2'd0,
    OUT_CONNECTED = 2'd1,
    OUT_NO_NBR    = 2'd2,
    OUT_NONE      = 2'd3
  } outcome_t;

  typedef enum logic [1:0] {
    DIR_NORTH = 2'd0,
    DIR_EAST  = 2'd1,
    DIR_SOUTH = 2'd2,
    DIR_WEST  = 2'd3
  } dir_t;

  typedef struct packed {
    logic par_re;
    logic par_we;
    logic wall_re;
    logic wall_we;
  } store_ctl_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(DIM_MAX)) begin
      r = DIM_W'(DIM_MAX);
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/union_find_maze_carver.sv
// Top level of the union-find maze carver: sequencer, registers and result stage.
//
// Usage: items arrive on in_valid/in_stall with in_kind, in_room and in_direction;
// one result per item leaves on out_valid/out_stall. Geometry is set through the
// cfg_we/cfg_index/cfg_wdata port, and the user must set it only while the block
// is idle, as the block does not enforce this; values are clamped to 1..32 rooms
// per side. A room outside the grid goes straight to the result stage, a read
// item after one wall read. A try item first runs the remainder step for the
// column (then a wall read and the result stage if there is no neighbour), then
// walks parent links for the room and for its neighbour at one link per cycle
// through the single parent memory read port; the link write goes with the last
// walk cycle, and the two wall read-modify-writes follow unless the rooms are
// already joined.
// One item is worked on at a time; the next is accepted in the cycle after a result
// enters the output register. While the receiver stalls, the next item is still
// taken and finished, then waits with in_stall high until the register frees.
// After reset a clearing pass sets every parent entry to its own index and every
// room to all walls present; in_stall stays high meanwhile.
module union_find_maze_carver #(
  parameter int unsigned MAX_ROOMS = umc_pkg::MAX_ROOMS_DFLT
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_kind,
  input  logic [umc_pkg::ROOM_W-1:0]  in_room,
  input  logic [1:0]                  in_direction,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  out_outcome,
  output logic                        out_wall_north,
  output logic                        out_wall_east,
  output logic                        out_wall_south,
  output logic                        out_wall_west,
  output logic [umc_pkg::ROOM_W-1:0]  out_merges_done,
  output logic                        out_complete,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [umc_pkg::DIM_W-1:0]   cfg_wdata
);
  import umc_pkg::*;

  localparam int unsigned AW = $clog2(MAX_ROOMS);

  typedef enum logic [8:0] {
    ST_CLEAR  = 9'b000000001,
    ST_IDLE   = 9'b000000010,
    ST_DIV    = 9'b000000100,
    ST_FIND_A = 9'b000001000,
    ST_FIND_B = 9'b000010000,
    ST_WALL   = 9'b000100000,
    ST_MERGE1 = 9'b001000000,
    ST_MERGE2 = 9'b010000000,
    ST_DONE   = 9'b100000000
  } state_t;

  state_t            state_r, state_nxt;
  logic [AW-1:0]     clr_r, clr_nxt;
  logic [DIM_W-1:0]  wide_r, wide_nxt;
  logic [DIM_W-1:0]  high_r, high_nxt;
  logic [ROOM_W-1:0] merge_r, merge_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic [ROOM_W-1:0] room_r, room_nxt;
  dir_t              dir_r, dir_nxt;
  logic [AW-1:0]     cur_r, cur_nxt;
  logic [AW-1:0]     root_a_r, root_a_nxt;
  outcome_t          outcome_r, outcome_nxt;
  logic [WALL_W-1:0] walls_r, walls_nxt;
  outcome_t          out_outcome_r, out_outcome_nxt;
  logic [WALL_W-1:0] out_walls_r, out_walls_nxt;
  logic [ROOM_W-1:0] out_merges_r, out_merges_nxt;
  logic              out_complete_r, out_complete_nxt;

  logic [PROD_W-1:0] prod;
  logic [SIZE_W-1:0] size;
  logic [SIZE_W-1:0] size_m1;
  logic [SIZE_W-1:0] room_x;
  logic [SIZE_W-1:0] wide_x;
  logic [SIZE_W-1:0] other_x;
  logic [AW-1:0]     room_idx;
  logic [AW-1:0]     other_idx;
  logic              nbr_ok;
  logic [WALL_W-1:0] own_mask;
  logic [WALL_W-1:0] opp_mask;

  logic              div_start;
  logic              div_done;
  logic [DIM_W-1:0]  col;

  store_ctl_t        ctl;
  logic [AW-1:0]     par_raddr, par_waddr, par_wdata, par_rdata;
  logic [AW-1:0]     wall_raddr, wall_waddr;
  logic [WALL_W-1:0] wall_wdata, wall_rdata;

  umc_divmod u_divmod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (in_room),
    .divisor   (wide_r),
    .done      (div_done),
    .remainder (col)
  );

  umc_store #(
    .MAX_ROOMS (MAX_ROOMS)
  ) u_store (
    .clk        (clk),
    .ctl        (ctl),
    .par_raddr  (par_raddr),
    .par_waddr  (par_waddr),
    .par_wdata  (par_wdata),
    .par_rdata  (par_rdata),
    .wall_raddr (wall_raddr),
    .wall_waddr (wall_waddr),
    .wall_wdata (wall_wdata),
    .wall_rdata (wall_rdata)
  );

  assign prod    = PROD_W'(wide_r) * PROD_W'(high_r);
  assign size    = (32'(prod) > MAX_ROOMS) ? SIZE_W'(MAX_ROOMS) : SIZE_W'(prod);
  assign size_m1 = size - SIZE_W'(1);
  assign room_x  = {1'b0, room_r};
  assign wide_x  = SIZE_W'(wide_r);
  assign room_idx = AW'(room_r);
  assign own_mask = WALL_W'(1) << dir_r;
  assign opp_mask = WALL_W'(1) << 2'(dir_r + 2'd2);

  always_comb begin
    nbr_ok  = 1'b0;
    other_x = room_x;
    unique case (dir_r)
      DIR_NORTH: begin
        other_x = room_x + wide_x;
        nbr_ok  = other_x < size;
      end
      DIR_EAST: begin
        other_x = room_x + SIZE_W'(1);
        nbr_ok  = ({1'b0, col} + (DIM_W + 1)'(1) < {1'b0, wide_r}) && (other_x < size);
      end
      DIR_SOUTH: begin
        other_x = room_x - wide_x;
        nbr_ok  = room_x >= wide_x;
      end
      DIR_WEST: begin
        other_x = room_x - SIZE_W'(1);
        nbr_ok  = col != '0;
      end
      default: begin
        other_x = room_x;
        nbr_ok  = 1'b0;
      end
    endcase
  end

  assign other_idx = AW'(other_x);

  always_comb begin
    wide_nxt = wide_r;
    high_nxt = high_r;
    if (cfg_we) begin
      if (cfg_index == CFG_WIDE) begin
        wide_nxt = clamp_dim(cfg_wdata);
      end else begin
        high_nxt = clamp_dim(cfg_wdata);
      end
    end
  end

  always_comb begin
    state_nxt        = state_r;
    clr_nxt          = clr_r;
    merge_nxt        = merge_r;
    room_nxt         = room_r;
    dir_nxt          = dir_r;
    cur_nxt          = cur_r;
    root_a_nxt       = root_a_r;
    outcome_nxt      = outcome_r;
    walls_nxt        = walls_r;
    out_outcome_nxt  = out_outcome_r;
    out_walls_nxt    = out_walls_r;
    out_merges_nxt   = out_merges_r;
    out_complete_nxt = out_complete_r;
    out_valid_nxt    = out_valid_r && out_stall;
    div_start        = 1'b0;
    ctl              = '0;
    par_raddr        = cur_r;
    par_waddr        = cur_r;
    par_wdata        = root_a_r;
    wall_raddr       = room_idx;
    wall_waddr       = room_idx;
    wall_wdata       = wall_rdata;

    unique case (state_r)
      ST_CLEAR: begin
        ctl.par_we  = 1'b1;
        ctl.wall_we = 1'b1;
        par_waddr   = clr_r;
        par_wdata   = clr_r;
        wall_waddr  = clr_r;
        wall_wdata  = WALLS_ALL;
        if (clr_r == AW'(MAX_ROOMS - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_nxt = clr_r + AW'(1);
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          room_nxt = in_room;
          dir_nxt  = dir_t'(in_direction);
          if ({1'b0, in_room} >= size) begin
            outcome_nxt = OUT_NONE;
            walls_nxt   = '0;
            state_nxt   = ST_DONE;
          end else if (in_kind == KIND_READ) begin
            outcome_nxt = OUT_NONE;
            ctl.wall_re = 1'b1;
            wall_raddr  = AW'(in_room);
            state_nxt   = ST_WALL;
          end else begin
            div_start = 1'b1;
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          if (!nbr_ok) begin
            outcome_nxt = OUT_NO_NBR;
            ctl.wall_re = 1'b1;
            state_nxt   = ST_WALL;
          end else begin
            cur_nxt    = room_idx;
            ctl.par_re = 1'b1;
            par_raddr  = room_idx;
            state_nxt  = ST_FIND_A;
          end
        end
      end
      ST_FIND_A: begin
        ctl.par_re = 1'b1;
        if (par_rdata == cur_r) begin
          root_a_nxt = cur_r;
          cur_nxt    = other_idx;
          par_raddr  = other_idx;
          state_nxt  = ST_FIND_B;
        end else begin
          cur_nxt   = par_rdata;
          par_raddr = par_rdata;
        end
      end
      ST_FIND_B: begin
        if (par_rdata == cur_r) begin
          ctl.wall_re = 1'b1;
          if (cur_r == root_a_r) begin
            outcome_nxt = OUT_CONNECTED;
            state_nxt   = ST_WALL;
          end else begin
            ctl.par_we  = 1'b1;
            outcome_nxt = OUT_REMOVED;
            state_nxt   = ST_MERGE1;
          end
        end else begin
          ctl.par_re = 1'b1;
          cur_nxt    = par_rdata;
          par_raddr  = par_rdata;
        end
      end
      ST_MERGE1: begin
        ctl.wall_we = 1'b1;
        wall_wdata  = wall_rdata & ~own_mask;
        walls_nxt   = wall_rdata & ~own_mask;
        ctl.wall_re = 1'b1;
        wall_raddr  = other_idx;
        if ({1'b0, merge_r} < size_m1) begin
          merge_nxt = merge_r + ROOM_W'(1);
        end
        state_nxt = ST_MERGE2;
      end
      ST_MERGE2: begin
        ctl.wall_we = 1'b1;
        wall_waddr  = other_idx;
        wall_wdata  = wall_rdata & ~opp_mask;
        state_nxt   = ST_DONE;
      end
      ST_WALL: begin
        walls_nxt = wall_rdata;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt    = 1'b1;
          out_outcome_nxt  = outcome_r;
          out_walls_nxt    = walls_r;
          out_merges_nxt   = merge_r;
          out_complete_nxt = {1'b0, merge_r} >= size_m1;
          state_nxt        = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      wide_r      <= DIM_W'(DIM_RESET);
      high_r      <= DIM_W'(DIM_RESET);
      merge_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      wide_r      <= wide_nxt;
      high_r      <= high_nxt;
      merge_r     <= merge_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    room_r         <= room_nxt;
    dir_r          <= dir_nxt;
    cur_r          <= cur_nxt;
    root_a_r       <= root_a_nxt;
    outcome_r      <= outcome_nxt;
    walls_r        <= walls_nxt;
    out_outcome_r  <= out_outcome_nxt;
    out_walls_r    <= out_walls_nxt;
    out_merges_r   <= out_merges_nxt;
    out_complete_r <= out_complete_nxt;
  end

  assign in_stall        = state_r != ST_IDLE;
  assign out_valid       = out_valid_r;
  assign out_outcome     = out_outcome_r;
  assign out_wall_north  = out_walls_r[0];
  assign out_wall_east   = out_walls_r[1];
  assign out_wall_south  = out_walls_r[2];
  assign out_wall_west   = out_walls_r[3];
  assign out_merges_done = out_merges_r;
  assign out_complete    = out_complete_r;

`ifndef NO_ASSERTIONS
  a_merge_only_on_link: assert property (@(posedge clk) disable iff (!rst_n)
    (merge_r != $past(merge_r)) |-> ($past(state_r) == ST_MERGE1))
    else $error("merge count moved outside a link step");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV))
    else $error("remainder finished outside its wait state");

  a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !out_valid_r)
    else $error("result offered during clearing pass");

  a_merge_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MERGE1) && ({1'b0, merge_r} >= size_m1) |=> $stable(merge_r))
    else $error("merge count passed its limit");
`endif

endmodule

// File: hw/rtl/umc_divmod.sv
// Bit-serial restoring remainder unit: room index modulo row width.
module umc_divmod (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [umc_pkg::ROOM_W-1:0]  dividend,
  input  logic [umc_pkg::DIM_W-1:0]   divisor,
  output logic                        done,
  output logic [umc_pkg::DIM_W-1:0]   remainder
);
  import umc_pkg::*;

  localparam int unsigned CNT_W = $clog2(ROOM_W + 1);

  logic             busy_r, busy_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [ROOM_W-1:0] num_r, num_nxt;
  logic [DIM_W-1:0] den_r, den_nxt;
  logic [DIM_W-1:0] rem_r, rem_nxt;
  logic [DIM_W:0]   trial;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    trial    = {rem_r, num_r[ROOM_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(ROOM_W);
      num_nxt  = dividend;
      den_nxt  = divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        if (trial >= {1'b0, den_r}) begin
          rem_nxt = DIM_W'(trial - {1'b0, den_r});
        end else begin
          rem_nxt = DIM_W'(trial);
        end
        num_nxt = {num_r[ROOM_W-2:0], 1'b0};
        cnt_nxt = cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
  end

  assign done      = busy_r && (cnt_r == '0);
  assign remainder = rem_r;

endmodule

// File: hw/rtl/umc_store.sv
// Parent and wall memories, one write and one registered read port each.
module umc_store #(
  parameter int unsigned MAX_ROOMS = umc_pkg::MAX_ROOMS_DFLT,
  localparam int unsigned AW = $clog2(MAX_ROOMS)
) (
  input  logic                        clk,
  input  umc_pkg::store_ctl_t         ctl,
  input  logic [AW-1:0]               par_raddr,
  input  logic [AW-1:0]               par_waddr,
  input  logic [AW-1:0]               par_wdata,
  output logic [AW-1:0]               par_rdata,
  input  logic [AW-1:0]               wall_raddr,
  input  logic [AW-1:0]               wall_waddr,
  input  logic [umc_pkg::WALL_W-1:0]  wall_wdata,
  output logic [umc_pkg::WALL_W-1:0]  wall_rdata
);
  import umc_pkg::*;

  logic [AW-1:0]     par_mem  [MAX_ROOMS];
  logic [WALL_W-1:0] wall_mem [MAX_ROOMS];
  logic [AW-1:0]     par_rdata_r;
  logic [WALL_W-1:0] wall_rdata_r;

  always_ff @(posedge clk) begin
    if (ctl.par_we) begin
      par_mem[par_waddr] <= par_wdata;
    end
    if (ctl.par_re) begin
      par_rdata_r <= par_mem[par_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wall_we) begin
      wall_mem[wall_waddr] <= wall_wdata;
    end
    if (ctl.wall_re) begin
      wall_rdata_r <= wall_mem[wall_raddr];
    end
  end

  assign par_rdata  = par_rdata_r;
  assign wall_rdata = wall_rdata_r;

endmodule

// File: tb/sv/maze_carve_checker.sv
`timescale 1ns / 100ps
// Checker: mirrors the carver's sets, walls and merge count and compares every result item.
module maze_carve_checker #(
  parameter int unsigned MAX_ROOMS = umc_pkg::MAX_ROOMS_DFLT
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic                        in_kind,
  input  logic [umc_pkg::ROOM_W-1:0]  in_room,
  input  logic [1:0]                  in_direction,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [1:0]                  out_outcome,
  input  logic                        out_wall_north,
  input  logic                        out_wall_east,
  input  logic                        out_wall_south,
  input  logic                        out_wall_west,
  input  logic [umc_pkg::ROOM_W-1:0]  out_merges_done,
  input  logic                        out_complete,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [umc_pkg::DIM_W-1:0]   cfg_wdata,
  input  logic                        run_done,
  output int                          fail_count
);
  import umc_pkg::*;

  typedef struct packed {
    outcome_t             outcome;
    logic [WALL_W-1:0]    walls;
    logic [ROOM_W-1:0]    merges;
    logic                 complete;
  } carve_result_t;

  logic [ROOM_W-1:0] set_parent [MAX_ROOMS];
  logic [WALL_W-1:0] room_walls [MAX_ROOMS];
  int unsigned       merges_made;
  logic [DIM_W-1:0]  wide_reg;
  logic [DIM_W-1:0]  high_reg;
  carve_result_t     due_results [$];
  int                fails = 0;

  assign fail_count = fails;

  task automatic report(string what, int got, int want);
    if (fails < 100) begin
      $display("%0t mismatch: %s got %0d expected %0d", $time, what, got, want);
    end
    fails++;
  endtask

  function automatic int unsigned fit_dim(logic [DIM_W-1:0] v);
    if (v == '0) return 1;
    if (v > DIM_MAX) return DIM_MAX;
    return 32'(v);
  endfunction

  function automatic int unsigned root_of(int unsigned r);
    int unsigned steps;
    for (steps = 0; steps < MAX_ROOMS; steps++) begin
      if (set_parent[r] == r) break;
      r = set_parent[r];
    end
    return r;
  endfunction

  function automatic carve_result_t carve_step(logic kind, logic [ROOM_W-1:0] room, dir_t dir);
    carve_result_t res;
    int unsigned   w;
    int unsigned   size;
    int unsigned   col;
    int unsigned   nbr;
    int unsigned   root_a;
    int unsigned   root_b;
    logic          has_nbr;
    w = fit_dim(wide_reg);
    size = w * fit_dim(high_reg);
    if (size > MAX_ROOMS) size = MAX_ROOMS;
    res.outcome = OUT_NONE;
    res.walls = '0;
    if (room < size) begin
      if (kind == KIND_TRY) begin
        col = room % w;
        case (dir)
          DIR_NORTH: begin
            has_nbr = (room + w) < size;
            nbr = room + w;
          end
          DIR_EAST: begin
            has_nbr = (col + 1 < w) && (room + 1 < size);
            nbr = room + 1;
          end
          DIR_SOUTH: begin
            has_nbr = room >= w;
            nbr = room - w;
          end
          default: begin
            has_nbr = col > 0;
            nbr = room - 1;
          end
        endcase
        if (!has_nbr) begin
          res.outcome = OUT_NO_NBR;
        end else begin
          root_a = root_of(room);
          root_b = root_of(nbr);
          if (root_a == root_b) begin
            res.outcome = OUT_CONNECTED;
          end else begin
            set_parent[root_b] = ROOM_W'(root_a);
            room_walls[room][dir] = 1'b0;
            room_walls[nbr][dir ^ 2'd2] = 1'b0;
            if (merges_made < size - 1) merges_made++;
            res.outcome = OUT_REMOVED;
          end
        end
      end
      res.walls = room_walls[room];
    end
    res.merges = merges_made[ROOM_W-1:0];
    res.complete = merges_made >= size - 1;
    return res;
  endfunction

  always @(posedge clk) begin
    carve_result_t     want;
    logic [WALL_W-1:0] got_walls;
    string             wall_name [WALL_W];
    wall_name = '{"wall_north", "wall_east", "wall_south", "wall_west"};
    if (!rst_n) begin
      for (int i = 0; i < MAX_ROOMS; i++) begin
        set_parent[i] = ROOM_W'(i);
        room_walls[i] = WALLS_ALL;
      end
      merges_made = 0;
      wide_reg = DIM_W'(DIM_RESET);
      high_reg = DIM_W'(DIM_RESET);
      due_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          report("result item with none pending", out_outcome, 0);
        end else begin
          want = due_results.pop_front();
          got_walls = {out_wall_west, out_wall_south, out_wall_east, out_wall_north};
          if (out_outcome !== want.outcome) report("outcome", out_outcome, want.outcome);
          for (int d = 0; d < WALL_W; d++) begin
            if (got_walls[d] !== want.walls[d]) report(wall_name[d], got_walls[d], want.walls[d]);
          end
          if (out_merges_done !== want.merges) begin
            report("merges_done", out_merges_done, want.merges);
          end
          if (out_complete !== want.complete) report("complete", out_complete, want.complete);
        end
      end
      if (cfg_we) begin
        if (cfg_index == CFG_WIDE) begin
          wide_reg = cfg_wdata;
        end else begin
          high_reg = cfg_wdata;
        end
      end
      if (in_valid && !in_stall) begin
        due_results.push_back(carve_step(in_kind, in_room, dir_t'(in_direction)));
      end
      if (run_done && due_results.size() != 0) begin
        report("items left without a result", due_results.size(), 0);
        due_results.delete();
      end
    end
  end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
// Testbench top: drives the maze carver with directed and random items and gives the verdict.
module testbench;
  import umc_pkg::*;

  localparam int unsigned ROOMS    = MAX_ROOMS_DFLT;
  localparam longint     LIMIT_NS = 64'd30_000_000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                in_kind = KIND_TRY;
  logic [ROOM_W-1:0]   in_room = '0;
  logic [1:0]          in_direction = DIR_NORTH;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [1:0]          out_outcome;
  logic                out_wall_north;
  logic                out_wall_east;
  logic                out_wall_south;
  logic                out_wall_west;
  logic [ROOM_W-1:0]   out_merges_done;
  logic                out_complete;
  logic                cfg_we = 1'b0;
  logic                cfg_index = CFG_WIDE;
  logic [DIM_W-1:0]    cfg_wdata = '0;
  logic                run_done = 1'b0;
  int                  fail_count;

  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned burst_left = 0;
  bit          offering = 1'b0;

  union_find_maze_carver #(.MAX_ROOMS(ROOMS)) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_room         (in_room),
    .in_direction    (in_direction),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_outcome     (out_outcome),
    .out_wall_north  (out_wall_north),
    .out_wall_east   (out_wall_east),
    .out_wall_south  (out_wall_south),
    .out_wall_west   (out_wall_west),
    .out_merges_done (out_merges_done),
    .out_complete    (out_complete),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  maze_carve_checker #(.MAX_ROOMS(ROOMS)) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_room         (in_room),
    .in_direction    (in_direction),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_outcome     (out_outcome),
    .out_wall_north  (out_wall_north),
    .out_wall_east   (out_wall_east),
    .out_wall_south  (out_wall_south),
    .out_wall_west   (out_wall_west),
    .out_merges_done (out_merges_done),
    .out_complete    (out_complete),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .run_done        (run_done),
    .fail_count      (fail_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) results_seen <= results_seen + 1;
  end

  task automatic send_item(logic kind, logic [ROOM_W-1:0] room, dir_t dir);
    in_valid <= 1'b1;
    in_kind <= kind;
    in_room <= room;
    in_direction <= dir;
    offering = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      offering = 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60) : $urandom_range(0, 7);
    end else begin
      burst_left--;
    end
  endtask

  task automatic wait_drain();
    if (offering) begin
      in_valid <= 1'b0;
      offering = 1'b0;
    end
    while (results_seen != items_sent) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic carve_phase(logic [DIM_W-1:0] raw_w, logic [DIM_W-1:0] raw_h, int count);
    int unsigned w;
    int unsigned h;
    int unsigned size;
    int unsigned pick;
    w = (raw_w == 0) ? 1 : ((raw_w > DIM_MAX) ? DIM_MAX : raw_w);
    h = (raw_h == 0) ? 1 : ((raw_h > DIM_MAX) ? DIM_MAX : raw_h);
    size = w * h;
    cfg_we <= 1'b1;
    cfg_index <= CFG_WIDE;
    cfg_wdata <= raw_w;
    @(posedge clk);
    cfg_index <= CFG_HIGH;
    cfg_wdata <= raw_h;
    @(posedge clk);
    cfg_we <= 1'b0;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        send_item(KIND_TRY, ROOM_W'($urandom_range(0, size - 1)),
                  dir_t'($urandom_range(0, 3)));
      end else if (pick < 82) begin
        send_item(KIND_READ, ROOM_W'($urandom_range(0, size - 1)),
                  dir_t'($urandom_range(0, 3)));
      end else if (pick < 90 || size >= ROOMS) begin
        send_item(1'($urandom_range(0, 1)), ROOM_W'($urandom_range(0, ROOMS - 1)),
                  dir_t'($urandom_range(0, 3)));
      end else begin
        send_item(1'($urandom_range(0, 1)), ROOM_W'($urandom_range(size, ROOMS - 1)),
                  dir_t'($urandom_range(0, 3)));
      end
    end
    wait_drain();
  endtask

  initial begin : receiver
    int unsigned mode;
    int unsigned span;
    bit          held;
    held = 1'b0;
    forever begin
      // hold off long enough for the carver to back up onto its input
      if (!held && items_sent >= 60) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
      end
      mode = $urandom_range(0, 3);
      span = (mode == 3) ? $urandom_range(1, 15) : $urandom_range(4, 60);
      repeat (span) begin
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= 1'($urandom_range(0, 1));
          2: out_stall <= ($urandom_range(0, 3) == 0);
          default: out_stall <= 1'b1;
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    send_item(KIND_READ, 10'd0,    DIR_NORTH);
    send_item(KIND_READ, 10'd1023, DIR_EAST);
    send_item(KIND_TRY,  10'd1023, DIR_WEST);
    send_item(KIND_TRY,  10'd64,   DIR_NORTH);
    send_item(KIND_READ, 10'd512,  DIR_SOUTH);
    send_item(KIND_TRY,  10'd63,   DIR_NORTH);
    send_item(KIND_TRY,  10'd0,    DIR_SOUTH);
    send_item(KIND_TRY,  10'd0,    DIR_WEST);
    send_item(KIND_TRY,  10'd7,    DIR_EAST);
    send_item(KIND_TRY,  10'd0,    DIR_NORTH);
    send_item(KIND_TRY,  10'd0,    DIR_EAST);
    send_item(KIND_TRY,  10'd8,    DIR_EAST);
    send_item(KIND_TRY,  10'd1,    DIR_NORTH);
    send_item(KIND_TRY,  10'd9,    DIR_SOUTH);
    send_item(KIND_TRY,  10'd9,    DIR_WEST);
    send_item(KIND_TRY,  10'd56,   DIR_SOUTH);
    send_item(KIND_TRY,  10'd63,   DIR_WEST);
    send_item(KIND_TRY,  10'd62,   DIR_NORTH);
    send_item(KIND_READ, 10'd9,    DIR_NORTH);
    send_item(KIND_READ, 10'd63,   DIR_WEST);
    wait_drain();

    carve_phase(6'd4,  6'd4,  50);
    carve_phase(6'd1,  6'd6,  25);
    carve_phase(6'd0,  6'd0,  10);
    carve_phase(6'd32, 6'd1,  30);
    carve_phase(6'd63, 6'd5,  40);
    carve_phase(6'd3,  6'd7,  50);
    carve_phase(6'd2,  6'd33, 30);
    carve_phase(6'd32, 6'd32, 20);
    carve_phase(6'd8,  6'd8,  35);

    repeat (2 * ROOMS + 32) @(posedge clk);
    run_done <= 1'b1;
    repeat (2) @(posedge clk);
    if (fail_count == 0) begin
      $display("union_find_maze_carver verification clean");
    end else begin
      $display("union_find_maze_carver verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(LIMIT_NS);
    $display("union_find_maze_carver verification failed");
    $finish;
  end

endmodule
